[src/pcc_pkg.sv]
// ============================================================================
// pcc_pkg
// Shared constants and codes for the page cache with clock replacement.
// ============================================================================
package pcc_pkg;

   localparam int ENTRIES   = 16;
   localparam int PAGE_BITS = 20;
   localparam int SLOT_BITS = 4;
   localparam int CNT_BITS  = 5;

   // request operations
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_ACCESS    = 2'd0;
   localparam logic [1:0] KIND_WRITEBACK = 2'd1;
   localparam logic [1:0] KIND_BYPASS    = 2'd2;
   localparam logic [1:0] KIND_DONE      = 2'd3;

   // register indexes
   localparam logic REG_ENTRIES = 1'b0;
   localparam logic REG_MODE    = 1'b1;

   // replacement modes
   localparam logic MODE_CLOCK   = 1'b0;
   localparam logic MODE_CLOCK_M = 1'b1;

endpackage

[src/pcc_tag_ram.sv]
// ============================================================================
// pcc_tag_ram
// Simple dual-port tag memory: one write port, one registered read port.
// ============================================================================
module pcc_tag_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[src/page_cache_clock_replacement_top.sv]
// ============================================================================
// page_cache_clock_replacement_top
// Fully associative page directory with CLOCK / CLOCK-M victim selection.
// ============================================================================
//
// Usage: a request is taken when start is high and busy is low. Every result
// shows for one cycle with rsp_valid high and cannot be held off; the last
// result of a request has rsp_last set. Tags live in a 16-entry memory with
// a registered read, so the lookup walks the filled slots one per cycle. When
// the directory is full the clock hand then sweeps one slot per cycle, but a
// CLOCK-M write-back of a slot whose use bit is clear holds the hand on it.
// Flush walks the filled slots as the lookup does; clear and bypass give a
// single result. Config writes are taken any time but must only be issued
// while the block is idle.
//
module page_cache_clock_replacement_top
   import pcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [PAGE_BITS-1:0]  req_page,
   // result channel
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_hit,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic [PAGE_BITS-1:0]  rsp_result_page,
   output logic                  rsp_last,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CNT_BITS-1:0]   csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP_RD,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [CNT_BITS-1:0] entries_ff;
   logic                mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CNT_BITS'(16);
         mode_ff    <= MODE_CLOCK;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ENTRIES: entries_ff <= csr_data;
            REG_MODE:    mode_ff    <= csr_data[0];
            default:     ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [ENTRIES-1:0]    use_ff, use_in;
   logic [ENTRIES-1:0]    dirty_ff, dirty_in;
   logic [SLOT_BITS-1:0]  hand_ff, hand_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;      // slot under evaluation
   logic                  write_ff, write_in;  // request is a write
   logic [PAGE_BITS-1:0]  page_ff, page_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [PAGE_BITS-1:0]  rsp_page_ff, rsp_page_in;
   logic                  rsp_last_ff, rsp_last_in;

   // tag memory port
   logic                  ram_we;
   logic [SLOT_BITS-1:0]  ram_waddr;
   logic [SLOT_BITS-1:0]  ram_raddr;
   logic [PAGE_BITS-1:0]  tag_q;

   pcc_tag_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (PAGE_BITS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (page_ff),
      .rd_addr (ram_raddr),
      .rd_data (tag_q)
   );

   // effective capacity and number of filled slots
   logic [CNT_BITS-1:0]  cap;
   logic [CNT_BITS-1:0]  nfill;
   logic [SLOT_BITS-1:0] idx_slot;
   logic [SLOT_BITS-1:0] hand_next;
   logic [CNT_BITS-1:0]  hand_inc;

   assign cap      = (entries_ff > CNT_BITS'(ENTRIES)) ? CNT_BITS'(ENTRIES) : entries_ff;
   assign nfill    = (fill_ff < cap) ? fill_ff : cap;
   assign idx_slot = idx_ff[SLOT_BITS-1:0];
   assign hand_inc = {1'b0, hand_ff} + CNT_BITS'(1);
   assign hand_next = (hand_inc >= cap) ? '0 : hand_inc[SLOT_BITS-1:0];

   assign busy = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------------
   // next-state logic
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      use_in       = use_ff;
      dirty_in     = dirty_ff;
      hand_in      = hand_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      write_in     = write_ff;
      page_in      = page_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_DONE;
      rsp_hit_in   = 1'b0;
      rsp_slot_in  = '0;
      rsp_page_in  = '0;
      rsp_last_in  = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_slot;
      ram_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = '0;  // slot 0 ready on entry to a scan
            if (start) begin
               write_in = (req_operation == OP_WRITE);
               page_in  = req_page;
               idx_in   = '0;
               case (req_operation)
                  OP_CLEAR: begin
                     if (cap != '0) begin
                        use_in   = '0;
                        dirty_in = '0;
                        hand_in  = '0;
                        fill_in  = '0;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
                  OP_FLUSH: begin
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     if (cap == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_BYPASS;
                        rsp_page_in  = req_page;
                        rsp_last_in  = 1'b1;
                     end else begin
                        state_in = ST_LOOKUP;
                     end
                  end
               endcase
            end
         end

         ST_LOOKUP: begin
            ram_raddr = idx_slot + SLOT_BITS'(1);
            if (idx_ff == nfill) begin
               // miss
               if (fill_ff < cap) begin
                  ram_we              = 1'b1;
                  ram_waddr           = fill_ff[SLOT_BITS-1:0];
                  use_in[ram_waddr]   = 1'b1;
                  dirty_in[ram_waddr] = write_ff;
                  fill_in             = fill_ff + CNT_BITS'(1);
                  rsp_valid_in        = 1'b1;
                  rsp_kind_in         = KIND_ACCESS;
                  rsp_slot_in         = fill_ff[SLOT_BITS-1:0];
                  rsp_page_in         = page_ff;
                  rsp_last_in         = 1'b1;
                  state_in            = ST_IDLE;
               end else begin
                  // hand beyond capacity restarts at slot 0
                  hand_in  = ({1'b0, hand_ff} < cap) ? hand_ff : '0;
                  state_in = ST_SWEEP_RD;
               end
            end else if (tag_q == page_ff) begin
               use_in[idx_slot] = 1'b1;
               if (write_ff) begin
                  dirty_in[idx_slot] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACCESS;
               rsp_hit_in   = 1'b1;
               rsp_slot_in  = idx_slot;
               rsp_page_in  = page_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end

         ST_SWEEP_RD: begin
            ram_raddr = hand_ff;
            state_in  = ST_SWEEP;
         end

         ST_SWEEP: begin
            // tag_q holds the tag of the slot under the hand
            ram_raddr = hand_next;
            if (mode_ff == MODE_CLOCK_M && dirty_ff[hand_ff]) begin
               // write back the old page; if use is clear, evict next cycle
               dirty_in[hand_ff] = 1'b0;
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_WRITEBACK;
               rsp_slot_in       = hand_ff;
               rsp_page_in       = tag_q;
               if (use_ff[hand_ff]) begin
                  use_in[hand_ff] = 1'b0;
                  hand_in         = hand_next;
               end else begin
                  ram_raddr = hand_ff;
               end
            end else if (use_ff[hand_ff]) begin
               use_in[hand_ff] = 1'b0;
               hand_in         = hand_next;
            end else begin
               ram_we            = 1'b1;
               ram_waddr         = hand_ff;
               use_in[hand_ff]   = 1'b1;
               dirty_in[hand_ff] = write_ff;
               hand_in           = hand_next;
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_ACCESS;
               rsp_slot_in       = hand_ff;
               rsp_page_in       = page_ff;
               rsp_last_in       = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            ram_raddr = idx_slot + SLOT_BITS'(1);
            if (idx_ff == nfill) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               if (dirty_ff[idx_slot]) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_WRITEBACK;
                  rsp_slot_in  = idx_slot;
                  rsp_page_in  = tag_q;
               end
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         use_ff       <= '0;
         dirty_ff     <= '0;
         hand_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         use_ff       <= use_in;
         dirty_ff     <= dirty_in;
         hand_ff      <= hand_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      write_ff    <= write_in;
      page_ff     <= page_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_page_ff <= rsp_page_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(ENTRIES))
      else $error("fill count above directory size");

   a_sweep_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (fill_ff >= cap && {1'b0, hand_ff} < cap))
      else $error("victim sweep on a directory that is not full");

   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_WRITEBACK) |-> !rsp_last)
      else $error("write-back marked as final result");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation != OP_CLEAR &&
       !(cap == '0 && (req_operation == OP_READ || req_operation == OP_WRITE)))
      |=> busy)
      else $error("multi-cycle request did not raise busy");

endmodule
